[rtl/core/ota_pkg.sv]
// Shared types, codes and defaults for the oscillator trim autotuner.
package ota_pkg;

    localparam int PERIOD_BITS_DEFAULT      = 24;
    localparam int MAX_AVERAGE_LOG2_DEFAULT = 7;

    localparam int SUM_BITS     = 32;
    localparam int TRIM_BITS    = 6;
    localparam int AVERAGE_BITS = 24;
    localparam int COUNT_BITS   = 8;
    localparam int SHIFT_BITS   = 3;
    localparam int WINDOW_BITS  = 24;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_PERIOD   = 2'd1,
        CMD_OVERFLOW = 2'd2,
        CMD_NONE     = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_TUNING = 2'd1,
        ST_OK     = 2'd2,
        ST_FAIL   = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_AVERAGE_SHIFT = 3'd0,
        CFG_WINDOW_MAX    = 3'd1,
        CFG_WINDOW_MIN    = 3'd2,
        CFG_TRIM_UPPER    = 3'd3,
        CFG_TRIM_LOWER    = 3'd4,
        CFG_ROUND_COUNT   = 3'd5
    } cfg_index_t;

    localparam logic [SHIFT_BITS-1:0]        AVERAGE_SHIFT_RESET = 3'd3;
    localparam logic [WINDOW_BITS-1:0]       WINDOW_MAX_RESET    = 24'hFFFFFF;
    localparam logic [WINDOW_BITS-1:0]       WINDOW_MIN_RESET    = 24'h000000;
    localparam logic signed [TRIM_BITS-1:0]  TRIM_UPPER_RESET    = 6'sd31;
    localparam logic signed [TRIM_BITS-1:0]  TRIM_LOWER_RESET    = -6'sd32;
    localparam logic [COUNT_BITS-1:0]        ROUND_COUNT_RESET   = 8'd8;

endpackage

[rtl/core/ota_req_if.sv]
// Request channel of the trim autotuner: command and captured period.
interface ota_req_if #(
    parameter int PERIOD_BITS = ota_pkg::PERIOD_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [PERIOD_BITS-1:0] period;

    modport source (output valid, output command, output period, input ready);
    modport sink   (input valid, input command, input period, output ready);
endinterface

[rtl/core/ota_res_if.sv]
// Result channel of the trim autotuner: trim, status and round average.
interface ota_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [ota_pkg::TRIM_BITS-1:0] trim_value;
    logic [1:0]                        status;
    logic                              trim_changed;
    logic                              average_valid;
    logic [ota_pkg::AVERAGE_BITS-1:0]  average;

    modport source (output valid, output trim_value, output status, output trim_changed,
                    output average_valid, output average, input ready);
    modport sink   (input valid, input trim_value, input status, input trim_changed,
                    input average_valid, input average, output ready);
endinterface

[rtl/core/oscillator_trim_autotune.sv]
// Oscillator trim autotuner: averages captured periods and steps a signed trim.
//
// Usage: each request carries a command (start, captured period, timer
// overflow) and a period. Every request yields exactly one result holding
// the trim after the request, the run status, a trim-step flag and, when a
// round completes, the round average.
// A request is taken in the cycle it is offered whenever the result
// register is empty or is being emptied in the same cycle, so one request
// per cycle is sustained. The result is registered and appears in the
// cycle after acceptance; the state update and result are computed
// combinationally by one 32-bit add, a barrel shift and the window compares.
// When the receiver stalls, the result is held and ready drops until it
// is taken; no result is lost.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// no request is in flight (unenforced); writes to unknown indexes are dropped.
// Reset: the trim, sum and counters clear, status is idle, the result
// register is empty and the configuration returns to its defaults.
module oscillator_trim_autotune #(
    parameter int PERIOD_BITS      = ota_pkg::PERIOD_BITS_DEFAULT,
    parameter int MAX_AVERAGE_LOG2 = ota_pkg::MAX_AVERAGE_LOG2_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ota_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ota_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    ota_req_if.sink                              request,
    ota_res_if.source                            result
);

    localparam int EFF_BITS = 4;
    localparam logic [EFF_BITS-1:0] MAX_SHIFT = EFF_BITS'(MAX_AVERAGE_LOG2);

    // configuration
    logic [ota_pkg::SHIFT_BITS-1:0]         average_shift_reg;
    logic [ota_pkg::WINDOW_BITS-1:0]        window_max_reg;
    logic [ota_pkg::WINDOW_BITS-1:0]        window_min_reg;
    logic signed [ota_pkg::TRIM_BITS-1:0]   trim_upper_reg;
    logic signed [ota_pkg::TRIM_BITS-1:0]   trim_lower_reg;
    logic [ota_pkg::COUNT_BITS-1:0]         round_count_reg;

    // run state
    logic signed [ota_pkg::TRIM_BITS-1:0]   trim_reg, trim_next;
    logic [ota_pkg::SUM_BITS-1:0]           period_sum_reg, period_sum_next;
    logic [ota_pkg::COUNT_BITS-1:0]         samples_left_reg, samples_left_next;
    logic [ota_pkg::COUNT_BITS-1:0]         rounds_left_reg, rounds_left_next;
    ota_pkg::status_t                       run_status_reg, run_status_next;

    // result register
    logic                                   out_valid_reg;
    logic                                   changed_reg, changed_next;
    logic                                   avg_valid_reg, avg_valid_next;
    logic [ota_pkg::AVERAGE_BITS-1:0]       average_reg, average_next;

    logic                                   accept;
    logic [PERIOD_BITS-1:0]                 period_in;
    logic [EFF_BITS-1:0]                    eff_shift;
    logic [ota_pkg::COUNT_BITS-1:0]         samples_reload;
    logic [ota_pkg::SUM_BITS-1:0]           sum_add;
    logic [ota_pkg::COUNT_BITS-1:0]         samples_dec;
    logic [ota_pkg::COUNT_BITS-1:0]         rounds_dec;
    logic [ota_pkg::SUM_BITS-1:0]           avg_full;
    ota_pkg::command_t                      cmd;

    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign cmd           = ota_pkg::command_t'(request.command);
    assign period_in     = request.period;

    assign eff_shift = ({1'b0, average_shift_reg} > MAX_SHIFT)
                       ? MAX_SHIFT : {1'b0, average_shift_reg};
    // the shift never exceeds seven, so a reload of up to 128 fits 8 bits
    assign samples_reload = ota_pkg::COUNT_BITS'(9'd1 << eff_shift);
    assign sum_add        = period_sum_reg + ota_pkg::SUM_BITS'(period_in);
    assign samples_dec    = samples_left_reg - 8'd1;
    assign rounds_dec     = rounds_left_reg - 8'd1;
    assign avg_full       = sum_add >> eff_shift;

    always_comb
    begin
        trim_next         = trim_reg;
        period_sum_next   = period_sum_reg;
        samples_left_next = samples_left_reg;
        rounds_left_next  = rounds_left_reg;
        run_status_next   = run_status_reg;
        changed_next      = 1'b0;
        avg_valid_next    = 1'b0;
        average_next      = '0;

        case (cmd)
            ota_pkg::CMD_START:
            begin
                run_status_next   = ota_pkg::ST_TUNING;
                rounds_left_next  = round_count_reg;
                period_sum_next   = '0;
                samples_left_next = samples_reload;
            end
            ota_pkg::CMD_PERIOD:
            begin
                if (run_status_reg == ota_pkg::ST_TUNING)
                begin
                    period_sum_next   = sum_add;
                    samples_left_next = samples_dec;
                    if (samples_dec == '0)
                    begin
                        avg_valid_next = 1'b1;
                        average_next   = avg_full[ota_pkg::AVERAGE_BITS-1:0];
                        if (avg_full > ota_pkg::SUM_BITS'(window_max_reg))
                        begin
                            if (trim_reg > trim_lower_reg)
                            begin
                                trim_next    = trim_reg - 6'sd1;
                                changed_next = 1'b1;
                            end
                        end
                        else if (avg_full < ota_pkg::SUM_BITS'(window_min_reg))
                        begin
                            if (trim_reg < trim_upper_reg)
                            begin
                                trim_next    = trim_reg + 6'sd1;
                                changed_next = 1'b1;
                            end
                        end
                        rounds_left_next = rounds_dec;
                        if (rounds_dec == '0)
                        begin
                            run_status_next = ota_pkg::ST_OK;
                            period_sum_next = '0;
                        end
                        else
                        begin
                            period_sum_next   = '0;
                            samples_left_next = samples_reload;
                        end
                    end
                end
            end
            ota_pkg::CMD_OVERFLOW:
            begin
                if (run_status_reg == ota_pkg::ST_TUNING)
                begin
                    run_status_next = ota_pkg::ST_FAIL;
                end
            end
            default:
            begin
                // drop unknown command, state unchanged
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_shift_reg <= ota_pkg::AVERAGE_SHIFT_RESET;
            window_max_reg    <= ota_pkg::WINDOW_MAX_RESET;
            window_min_reg    <= ota_pkg::WINDOW_MIN_RESET;
            trim_upper_reg    <= ota_pkg::TRIM_UPPER_RESET;
            trim_lower_reg    <= ota_pkg::TRIM_LOWER_RESET;
            round_count_reg   <= ota_pkg::ROUND_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ota_pkg::CFG_AVERAGE_SHIFT:
                    average_shift_reg <= cfg_data[ota_pkg::SHIFT_BITS-1:0];
                ota_pkg::CFG_WINDOW_MAX:
                    window_max_reg <= cfg_data[ota_pkg::WINDOW_BITS-1:0];
                ota_pkg::CFG_WINDOW_MIN:
                    window_min_reg <= cfg_data[ota_pkg::WINDOW_BITS-1:0];
                ota_pkg::CFG_TRIM_UPPER:
                    trim_upper_reg <= $signed(cfg_data[ota_pkg::TRIM_BITS-1:0]);
                ota_pkg::CFG_TRIM_LOWER:
                    trim_lower_reg <= $signed(cfg_data[ota_pkg::TRIM_BITS-1:0]);
                ota_pkg::CFG_ROUND_COUNT:
                    round_count_reg <= cfg_data[ota_pkg::COUNT_BITS-1:0];
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg         <= '0;
            period_sum_reg   <= '0;
            samples_left_reg <= '0;
            rounds_left_reg  <= '0;
            run_status_reg   <= ota_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                trim_reg         <= trim_next;
                period_sum_reg   <= period_sum_next;
                samples_left_reg <= samples_left_next;
                rounds_left_reg  <= rounds_left_next;
                run_status_reg   <= run_status_next;
                out_valid_reg    <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            changed_reg   <= changed_next;
            avg_valid_reg <= avg_valid_next;
            average_reg   <= average_next;
        end
    end

    // trim and status registers hold the post-request values directly
    assign result.valid         = out_valid_reg;
    assign result.trim_value    = trim_reg;
    assign result.status        = run_status_reg;
    assign result.trim_changed  = changed_reg;
    assign result.average_valid = avg_valid_reg;
    assign result.average       = average_reg;

endmodule
